/* rtl/tamper_seal_accumulator_macros.svh */
// ----------------------------------------------------------------------------
// Tamper seal accumulator: assertion macros
// Shorthand for clocked, reset-qualified checks. Expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef TAMPER_SEAL_ACCUMULATOR_MACROS_SVH
`define TAMPER_SEAL_ACCUMULATOR_MACROS_SVH

// Property must hold at every edge outside reset.
`define TSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in this cycle requires consequent in the next one.
`define TSA_IMPLIES_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/tsa_pkg.sv */
// ----------------------------------------------------------------------------
// tsa_pkg
// Widths, mixer constants, command codes and shared types for the seal block.
// ----------------------------------------------------------------------------
package tsa_pkg;

  localparam int WORD_W  = 64;
  localparam int HALF_W  = WORD_W / 2;
  localparam int SCORE_W = 32;

  localparam logic [WORD_W-1:0] MIX_M0   = 64'hff51afd7ed558ccd;
  localparam logic [WORD_W-1:0] MIX_M1   = 64'hc4ceb9fe1a85ec53;
  localparam logic [WORD_W-1:0] GOLDEN   = 64'h9E3779B97F4A7C15;
  localparam logic [WORD_W-1:0] FLAG_X   = 64'hD6E8FEB86659FD93;
  localparam logic [WORD_W-1:0] WORD_X   = 64'hA0761D6478BD642F;
  localparam logic [WORD_W-1:0] COMMIT_X = 64'h5A17C0DEF00D5A17;

  localparam int SHIFT_A  = 33;
  localparam int SHIFT_B  = 29;
  localparam int SHIFT_C  = 32;
  localparam int ROT_FLAG = 17;

  localparam logic [1:0] CMD_FLAG     = 2'd0;
  localparam logic [1:0] CMD_WORD     = 2'd1;
  localparam logic [1:0] CMD_WEIGHTED = 2'd2;
  localparam logic [1:0] CMD_KEY      = 2'd3;

  // status of the shared multiplier
  typedef struct packed {
    logic busy;
    logic done;
  } tsa_mul_stat_t;

endpackage

/* rtl/tamper_seal_accumulator.sv */
// ----------------------------------------------------------------------------
// tamper_seal_accumulator
// 64-bit tamper seal with flag, word and weighted folds and key derivation,
// run by a small sequencer around one shared iterative multiplier.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | cmd, value, salt, weight, mask, thr
//  out     | output    | out_valid/out_stall| key, seal_delta, committed_flag
//  cfg     | input     | cfg_we             | cfg_wdata (seal seed)
//
//  One word at a time: in_stall stays high until the sequencer is idle again.
//  Flag folds, word folds, key queries and weighted folds that commit a
//  non-zero word run through the shared multiplier; zero operands, a zero
//  seal delta and weighted folds without commit skip it.
//  Reset (rst_n low, synchronous) clears seed, seal, score, evidence, committed.
//  A pending result waiting on out_stall holds the sequencer only at its end.
// ----------------------------------------------------------------------------
`include "tamper_seal_accumulator_macros.svh"

module tamper_seal_accumulator import tsa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic [WORD_W-1:0]  in_value,
  input  logic [WORD_W-1:0]  in_salt,
  input  logic [SCORE_W-1:0] in_weight,
  input  logic [WORD_W-1:0]  in_evidence_mask,
  input  logic [SCORE_W-1:0] in_threshold,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [WORD_W-1:0]  out_key,
  output logic [WORD_W-1:0]  out_seal_delta,
  output logic               out_committed_flag,
  input  logic               cfg_we,
  input  logic [WORD_W-1:0]  cfg_wdata
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_FLAGW = 3'd2;
  localparam logic [2:0] S_WCHK  = 3'd3;
  localparam logic [2:0] S_MIXA  = 3'd4;
  localparam logic [2:0] S_MIXB  = 3'd5;
  localparam logic [2:0] S_MIXC  = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0]         state_r, state_nxt;
  logic [1:0]         cmd_r;
  logic [WORD_W-1:0]  value_r, salt_r, mask_r;
  logic [SCORE_W-1:0] weight_r, thr_r;
  logic [WORD_W-1:0]  x_r, x_nxt, s_r, s_nxt, key_r, key_nxt;
  logic [WORD_W-1:0]  seal_r, seal_nxt, seed_r;
  logic [SCORE_W-1:0] score_r, score_nxt;
  logic [WORD_W-1:0]  evid_r, evid_nxt;
  logic               committed_r, committed_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]  out_key_r, out_delta_r;
  logic               out_committed_r;

  logic               in_acc, out_free, out_load;
  logic [WORD_W-1:0]  t_add, mixa_v, mixb_v, mix_out, rot_seal, delta, commit_word;
  logic               ev_multi, go;
  logic               mul_wait;

  logic               mul_start;
  logic [WORD_W-1:0]  mul_a, mul_b, mul_prod;
  tsa_mul_stat_t      mul_stat;

  tsa_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .product (mul_prod),
    .stat    (mul_stat)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == S_FIN) && out_free;
  assign mul_wait = state_r inside {S_FLAGW, S_MIXB, S_MIXC};

  assign t_add       = x_r + s_r;
  assign mixa_v      = t_add ^ (t_add >> SHIFT_A);
  assign mixb_v      = mul_prod ^ (mul_prod >> SHIFT_B);
  assign mix_out     = mul_prod ^ (mul_prod >> SHIFT_C);
  assign rot_seal    = {seal_r[WORD_W-ROT_FLAG-1:0], seal_r[WORD_W-1:WORD_W-ROT_FLAG]};
  assign delta       = seal_r ^ seed_r;
  assign commit_word = {{(WORD_W-SCORE_W){1'b0}}, score_r} ^ evid_r;
  // at least two evidence bits set
  assign ev_multi    = (evid_r & (evid_r - 64'd1)) != '0;
  assign go          = (score_r >= thr_r) && ev_multi && !committed_r;

  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    s_nxt         = s_r;
    key_nxt       = key_r;
    seal_nxt      = seal_r;
    score_nxt     = score_r;
    evid_nxt      = evid_r;
    committed_nxt = committed_r;
    mul_start     = 1'b0;
    mul_a         = mixa_v;
    mul_b         = MIX_M0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          key_nxt   = '0;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (cmd_r)
          CMD_FLAG: begin
            if (value_r == '0) begin
              state_nxt = S_FIN;
            end else begin
              mul_start = 1'b1;
              mul_a     = rot_seal ^ salt_r ^ FLAG_X;
              mul_b     = (salt_r ^ GOLDEN) | 64'd1;
              state_nxt = S_FLAGW;
            end
          end
          CMD_WORD: begin
            if (value_r == '0) begin
              state_nxt = S_FIN;
            end else begin
              x_nxt     = seal_r ^ value_r;
              s_nxt     = salt_r ^ WORD_X;
              state_nxt = S_MIXA;
            end
          end
          CMD_WEIGHTED: begin
            if (weight_r == '0 || thr_r == '0 || value_r == '0) begin
              state_nxt = S_FIN;
            end else begin
              score_nxt = score_r + weight_r;
              evid_nxt  = evid_r | ((mask_r == '0) ? 64'd1 : mask_r);
              state_nxt = S_WCHK;
            end
          end
          default: begin
            if (delta == '0) begin
              state_nxt = S_FIN;
            end else begin
              x_nxt     = delta ^ salt_r;
              s_nxt     = salt_r ^ GOLDEN;
              state_nxt = S_MIXA;
            end
          end
        endcase
      end
      S_FLAGW: begin
        if (mul_stat.done) begin
          seal_nxt  = mul_prod + ((salt_r + WORD_X) | 64'd1);
          state_nxt = S_FIN;
        end
      end
      S_WCHK: begin
        state_nxt = S_FIN;
        if (go) begin
          committed_nxt = 1'b1;
          // a zero commit word leaves the seal alone
          if (commit_word != '0) begin
            x_nxt     = seal_r ^ commit_word;
            s_nxt     = salt_r ^ COMMIT_X ^ WORD_X;
            state_nxt = S_MIXA;
          end
        end
      end
      S_MIXA: begin
        mul_start = 1'b1;
        state_nxt = S_MIXB;
      end
      S_MIXB: begin
        if (mul_stat.done) begin
          mul_start = 1'b1;
          mul_a     = mixb_v;
          mul_b     = MIX_M1;
          state_nxt = S_MIXC;
        end
      end
      S_MIXC: begin
        if (mul_stat.done) begin
          if (cmd_r == CMD_KEY) begin
            key_nxt = mix_out;
          end else begin
            seal_nxt = mix_out;
          end
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // seed write reloads the seal; the user must write only while idle, the block does not enforce it
    if (cfg_we) begin
      seal_nxt = cfg_wdata;
    end
  end

  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      seed_r      <= '0;
      seal_r      <= '0;
      score_r     <= '0;
      evid_r      <= '0;
      committed_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      seal_r      <= seal_nxt;
      score_r     <= score_nxt;
      evid_r      <= evid_nxt;
      committed_r <= committed_nxt;
      if (cfg_we) begin
        seed_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r    <= in_cmd;
      value_r  <= in_value;
      salt_r   <= in_salt;
      weight_r <= in_weight;
      mask_r   <= in_evidence_mask;
      thr_r    <= in_threshold;
    end
    x_r   <= x_nxt;
    s_r   <= s_nxt;
    key_r <= key_nxt;
    if (out_load) begin
      out_key_r       <= key_r;
      out_delta_r     <= delta;
      out_committed_r <= committed_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_key            = out_key_r;
  assign out_seal_delta     = out_delta_r;
  assign out_committed_flag = out_committed_r;

  `TSA_IMPLIES_NEXT(a_commit_sticky, committed_r, committed_r, "committed flag dropped")
  `TSA_ASSERT(a_mul_no_restart, !(mul_start && mul_stat.busy), "multiplier restarted while busy")
  `TSA_ASSERT(a_mul_in_flight, !mul_wait || mul_stat.busy || mul_stat.done, "multiply never started")

endmodule

/* rtl/tsa_mul.sv */
// ----------------------------------------------------------------------------
// tsa_mul
// Iterative 64x64 low-half multiplier built on one 32x32 multiplier.
// Operands are latched on start; the product is valid while done is high.
// ----------------------------------------------------------------------------
module tsa_mul import tsa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WORD_W-1:0] a,
  input  logic [WORD_W-1:0] b,
  output logic [WORD_W-1:0] product,
  output tsa_mul_stat_t     stat
);

  localparam logic [1:0] STEP_LL   = 2'd0;
  localparam logic [1:0] STEP_LH   = 2'd1;
  localparam logic [1:0] STEP_LAST = 2'd3;

  logic [WORD_W-1:0] a_r, b_r, prod_r, acc_r, acc_nxt;
  logic [HALF_W-1:0] op_x, op_y;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt, done_r, done_nxt;

  // lo*lo, then the two cross terms; hi*hi falls above bit 63
  always_comb begin
    case (cnt_r)
      STEP_LL: begin
        op_x = a_r[HALF_W-1:0];
        op_y = b_r[HALF_W-1:0];
      end
      STEP_LH: begin
        op_x = a_r[HALF_W-1:0];
        op_y = b_r[WORD_W-1:HALF_W];
      end
      default: begin
        op_x = a_r[WORD_W-1:HALF_W];
        op_y = b_r[HALF_W-1:0];
      end
    endcase
  end

  always_comb begin
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      cnt_nxt  = STEP_LL;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 2'd1;
      if (cnt_r == STEP_LH) begin
        acc_nxt = prod_r;
      end else if (cnt_r != STEP_LL) begin
        acc_nxt = acc_r + {prod_r[HALF_W-1:0], {HALF_W{1'b0}}};
      end
      if (cnt_r == STEP_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= STEP_LL;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
    end
    if (busy_r) begin
      prod_r <= {HALF_W'(0), op_x} * {HALF_W'(0), op_y};
    end
    acc_r <= acc_nxt;
  end

  assign product   = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

/* tb/tsa_seal_checker.sv */
// ----------------------------------------------------------------------------
// tsa_seal_checker
// Watches the input, result and seed-write ports of the seal accumulator,
// predicts every result from its own copy of seal, score and evidence, and
// compares each accepted result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module tsa_seal_checker import tsa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic [WORD_W-1:0]  in_value,
  input  logic [WORD_W-1:0]  in_salt,
  input  logic [SCORE_W-1:0] in_weight,
  input  logic [WORD_W-1:0]  in_evidence_mask,
  input  logic [SCORE_W-1:0] in_threshold,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [WORD_W-1:0]  out_key,
  input  logic [WORD_W-1:0]  out_seal_delta,
  input  logic               out_committed_flag,
  input  logic               cfg_we,
  input  logic [WORD_W-1:0]  cfg_wdata,
  output int                 mismatches,
  output int                 pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [WORD_W-1:0] key;
    logic [WORD_W-1:0] seal_delta;
    logic              committed_flag;
  } seal_result_t;

  seal_result_t        expected_q[$];
  logic [WORD_W-1:0]   seed_r;
  logic [WORD_W-1:0]   seal_r;
  logic [SCORE_W-1:0]  score_r;
  logic [WORD_W-1:0]   evidence_r;
  logic                committed_r;
  int                  result_idx;

  initial begin
    mismatches      = 0;
    pending_results = 0;
    result_idx      = 0;
  end

  function automatic logic [WORD_W-1:0] mix64(logic [WORD_W-1:0] x, logic [WORD_W-1:0] s);
    x = x + s;
    x = x ^ (x >> SHIFT_A);
    x = x * MIX_M0;
    x = x ^ (x >> SHIFT_B);
    x = x * MIX_M1;
    x = x ^ (x >> SHIFT_C);
    return x;
  endfunction

  // zero word leaves the seal alone
  function automatic void fold_word(logic [WORD_W-1:0] w, logic [WORD_W-1:0] salt);
    if (w != '0) begin
      seal_r = mix64(seal_r ^ w, salt ^ WORD_X);
    end
  endfunction

  function automatic seal_result_t predict_result(
    logic [1:0] cmd, logic [WORD_W-1:0] value, logic [WORD_W-1:0] salt,
    logic [SCORE_W-1:0] weight, logic [WORD_W-1:0] mask, logic [SCORE_W-1:0] thr);
    seal_result_t      res;
    logic [WORD_W-1:0] m;
    logic [WORD_W-1:0] delta;
    logic              tripped;
    logic              fire;
    res.key = '0;
    case (cmd)
      CMD_FLAG: begin
        if (value != '0) begin
          m = (seal_r << ROT_FLAG) | (seal_r >> (WORD_W - ROT_FLAG));
          m = m ^ salt ^ FLAG_X;
          m = m * ((salt ^ GOLDEN) | 64'd1);
          m = m + ((salt + WORD_X) | 64'd1);
          seal_r = m;
        end
      end
      CMD_WORD: fold_word(value, salt);
      CMD_WEIGHTED: begin
        if (weight != '0 && thr != '0) begin
          tripped = (value != '0);
          if (tripped) begin
            score_r    = score_r + weight;
            evidence_r = evidence_r | ((mask != '0) ? mask : 64'd1);
          end
          // commit needs two or more evidence bits, and only once
          fire = tripped && (score_r >= thr) && ((evidence_r & (evidence_r - 1)) != '0)
                 && !committed_r;
          if (fire) begin
            fold_word({{(WORD_W-SCORE_W){1'b0}}, score_r} ^ evidence_r, salt ^ COMMIT_X);
            committed_r = 1'b1;
          end
        end
      end
      default: begin
        delta = seal_r ^ seed_r;
        if (delta != '0) begin
          res.key = mix64(delta ^ salt, salt ^ GOLDEN);
        end
      end
    endcase
    res.seal_delta     = seal_r ^ seed_r;
    res.committed_flag = committed_r;
    return res;
  endfunction

  function automatic void note_failure(string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] MISMATCH %s", $realtime, msg);
    end
  endfunction

  always @(posedge clk) begin : monitor
    seal_result_t got;
    seal_result_t want;
    if (!rst_n) begin
      seed_r      = '0;
      seal_r      = '0;
      score_r     = '0;
      evidence_r  = '0;
      committed_r = 1'b0;
      expected_q.delete();
    end else begin
      // a result can never belong to a word accepted on this same edge
      if (out_valid && !out_stall) begin
        got.key            = out_key;
        got.seal_delta     = out_seal_delta;
        got.committed_flag = out_committed_flag;
        if (expected_q.size() == 0) begin
          note_failure($sformatf("result %0d arrived with nothing expected: key %h delta %h c %b",
                                 result_idx, got.key, got.seal_delta, got.committed_flag));
        end else begin
          want = expected_q.pop_front();
          if (got.key !== want.key || got.seal_delta !== want.seal_delta ||
              got.committed_flag !== want.committed_flag) begin
            note_failure($sformatf(
              "result %0d: key exp %h got %h, delta exp %h got %h, committed exp %b got %b",
              result_idx, want.key, got.key, want.seal_delta, got.seal_delta,
              want.committed_flag, got.committed_flag));
          end
        end
        result_idx++;
      end
      if (cfg_we) begin
        seed_r = cfg_wdata;
        seal_r = cfg_wdata;
      end
      if (in_valid && !in_stall) begin
        expected_q = {expected_q, predict_result(in_cmd, in_value, in_salt, in_weight,
                                                 in_evidence_mask, in_threshold)};
      end
    end
    pending_results = expected_q.size();
  end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives the seal accumulator with a directed run over the special cases and
// then random words in phases of sender idling and receiver stalling, with a
// new seal seed written before each phase. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top import tsa_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_WORDS_PER_PHASE = 400;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_cmd = CMD_FLAG;
  logic [WORD_W-1:0]  in_value = '0;
  logic [WORD_W-1:0]  in_salt = '0;
  logic [SCORE_W-1:0] in_weight = '0;
  logic [WORD_W-1:0]  in_evidence_mask = '0;
  logic [SCORE_W-1:0] in_threshold = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [WORD_W-1:0]  out_key;
  logic [WORD_W-1:0]  out_seal_delta;
  logic               out_committed_flag;
  logic               cfg_we = 1'b0;
  logic [WORD_W-1:0]  cfg_wdata = '0;

  int mismatches;
  int pending_results;
  int src_idle_pct = 0;
  int rcv_stall_pct = 0;

  tamper_seal_accumulator u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_value           (in_value),
    .in_salt            (in_salt),
    .in_weight          (in_weight),
    .in_evidence_mask   (in_evidence_mask),
    .in_threshold       (in_threshold),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_key            (out_key),
    .out_seal_delta     (out_seal_delta),
    .out_committed_flag (out_committed_flag),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata)
  );

  tsa_seal_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_value           (in_value),
    .in_salt            (in_salt),
    .in_weight          (in_weight),
    .in_evidence_mask   (in_evidence_mask),
    .in_threshold       (in_threshold),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_key            (out_key),
    .out_seal_delta     (out_seal_delta),
    .out_committed_flag (out_committed_flag),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .mismatches         (mismatches),
    .pending_results    (pending_results)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
  end

  initial begin
    #2_000_000;
    $display("tamper_seal_accumulator test failed");
    $finish;
  end

  function automatic logic [WORD_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return WORD_W'($urandom_range(1, 255));
      3:       return 64'd1 << $urandom_range(0, WORD_W - 1);
      default: return rand64();
    endcase
  endfunction

  function automatic logic [SCORE_W-1:0] pick_score();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return SCORE_W'($urandom_range(1, 64));
      default: return $urandom;
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so the next word can follow without a gap.
  task automatic drive_word(input logic [1:0] cmd, input logic [WORD_W-1:0] value,
                            input logic [WORD_W-1:0] salt, input logic [SCORE_W-1:0] weight,
                            input logic [WORD_W-1:0] mask, input logic [SCORE_W-1:0] thr);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_cmd           <= cmd;
    in_value         <= value;
    in_salt          <= salt;
    in_weight        <= weight;
    in_evidence_mask <= mask;
    in_threshold     <= thr;
    in_valid         <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Hold input, drain every outstanding result, then load the new seed.
  task automatic write_seed(input logic [WORD_W-1:0] seed);
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    cfg_wdata <= seed;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int src_idle_by_phase[4];
    int rcv_stall_by_phase[4];
    logic [WORD_W-1:0] seed_by_phase[4];
    src_idle_by_phase  = '{0, 85, 0, 23};
    rcv_stall_by_phase = '{0, 0, 85, 23};
    seed_by_phase      = '{'1, rand64(), 64'h8000_0000_0000_0001, '0};

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // seal untouched since reset: key must be zero
    drive_word(CMD_KEY, rand64(), rand64(), $urandom, rand64(), $urandom);
    // zero operands leave the seal alone
    drive_word(CMD_FLAG, '0, rand64(), $urandom, rand64(), $urandom);
    drive_word(CMD_WORD, '0, rand64(), $urandom, rand64(), $urandom);
    // weighted fold disabled by zero weight, by zero threshold, and idle on zero flag
    drive_word(CMD_WEIGHTED, '1, rand64(), '0, rand64(), 32'd5);
    drive_word(CMD_WEIGHTED, 64'd1, rand64(), 32'd7, rand64(), '0);
    drive_word(CMD_WEIGHTED, '0, rand64(), 32'd7, rand64(), 32'd1);
    // threshold reached with one evidence bit (zero mask counts as bit 0): no commit
    drive_word(CMD_WEIGHTED, 64'd1, rand64(), '1, '0, '1);
    // score wraps to 3, two evidence bits, below threshold
    drive_word(CMD_WEIGHTED, '1, rand64(), 32'd4, 64'h100, '1);
    // score 0x101 equals evidence 0x101: commit with a zero word
    drive_word(CMD_WEIGHTED, 64'h8000_0000_0000_0000, rand64(), 32'hFE, '0, 32'h101);
    drive_word(CMD_KEY, rand64(), '0, $urandom, rand64(), $urandom);
    // no second commit
    drive_word(CMD_WEIGHTED, 64'd1, rand64(), 32'd1, 64'd4, 32'd1);
    drive_word(CMD_FLAG, 64'd1, '0, $urandom, rand64(), $urandom);
    drive_word(CMD_FLAG, '1, '1, $urandom, rand64(), $urandom);
    drive_word(CMD_KEY, rand64(), '0, $urandom, rand64(), $urandom);
    drive_word(CMD_WORD, '1, '0, $urandom, rand64(), $urandom);
    drive_word(CMD_WORD, 64'h8000_0000_0000_0000, '1, $urandom, rand64(), $urandom);
    drive_word(CMD_KEY, rand64(), '1, $urandom, rand64(), $urandom);
    drive_word(CMD_FLAG, rand64(), rand64(), $urandom, rand64(), $urandom);
    drive_word(CMD_WORD, rand64(), rand64(), $urandom, rand64(), $urandom);
    drive_word(CMD_KEY, rand64(), rand64(), $urandom, rand64(), $urandom);

    for (int ph = 0; ph < 4; ph++) begin
      write_seed(seed_by_phase[ph]);
      src_idle_pct  = src_idle_by_phase[ph];
      rcv_stall_pct = rcv_stall_by_phase[ph];
      for (int n = 0; n < RAND_WORDS_PER_PHASE; n++) begin
        drive_word(2'($urandom_range(0, 3)), pick_word(), pick_word(), pick_score(),
                   pick_word(), pick_score());
      end
    end

    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("tamper_seal_accumulator test passed");
    end else begin
      $display("tamper_seal_accumulator test failed");
    end
    $finish;
  end

endmodule
